[sv/seclip_pkg.sv]
// Package for the satellite eclipse detector: payload types, register codes, sequencer steps.
package seclip_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_EARTH_RADIUS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_SECONDS = 8'd1;

    localparam logic [23:0] EARTH_RADIUS_RESET = 24'd6378137;
    localparam logic [15:0] HOLD_SECONDS_RESET = 16'd1800;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_PREP    = 5'd11;
    localparam logic [STEP_W-1:0] STEP_COMPARE = 5'd21;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [31:0] sat_x;
        logic signed [31:0] sat_y;
        logic signed [31:0] sat_z;
        logic signed [31:0] sun_x;
        logic signed [31:0] sun_y;
        logic signed [31:0] sun_z;
        logic [31:0]        epoch_seconds;
    } item_t;

    typedef struct packed {
        logic in_eclipse;
        logic in_shadow_now;
    } result_t;

endpackage

[sv/satellite_eclipse_detector_core.sv]
// Cylindrical Earth-shadow eclipse detector on one shared 32x32 multiplier.
// The result is registered from the finish state, after 22 sequencer steps.
// One item at a time: 22 steps (18 on the multiplier), the finish state, then back to idle.
// Input stalls from the accepted beat until the result register takes the finished item.
// Reset (rst_n low, asynchronous): registers to 6378137 m and 1800 s, flag, shadow time cleared.
module satellite_eclipse_detector_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  seclip_pkg::item_t                 item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output seclip_pkg::result_t               result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [seclip_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [seclip_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import seclip_pkg::*;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg;

    logic [23:0] radius_reg;
    logic [15:0] hold_reg;
    logic        flag_reg, flag_next;
    logic [31:0] last_reg, last_next;
    logic        seen_reg, seen_next;

    logic [31:0] pm_reg [3];
    logic [31:0] sm_reg [3];
    logic [2:0]  neg_reg;
    logic [31:0] epoch_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] prod_reg;

    logic signed [64:0] dot_reg;
    logic [63:0]  pn_reg, ns_reg, diff_reg, dmag_reg;
    logic [47:0]  r2_reg;
    logic         le_reg, night_reg, shadow_reg;
    logic [127:0] lhs_reg, rhs_reg;

    logic    accept, done_fire;
    logic    result_valid_reg;
    result_t result_reg;

    assign cfg_ready    = 1'b1;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (item_valid) state_next = ST_RUN;
            ST_RUN:  if (step_reg == STEP_COMPARE) state_next = ST_DONE;
            ST_DONE: if (!result_valid_reg || !result_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        done_fire  = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            5'd0:  begin mul_a = pm_reg[0]; mul_b = sm_reg[0]; end
            5'd1:  begin mul_a = pm_reg[1]; mul_b = sm_reg[1]; end
            5'd2:  begin mul_a = pm_reg[2]; mul_b = sm_reg[2]; end
            5'd3:  begin mul_a = pm_reg[0]; mul_b = pm_reg[0]; end
            5'd4:  begin mul_a = pm_reg[1]; mul_b = pm_reg[1]; end
            5'd5:  begin mul_a = pm_reg[2]; mul_b = pm_reg[2]; end
            5'd6:  begin mul_a = sm_reg[0]; mul_b = sm_reg[0]; end
            5'd7:  begin mul_a = sm_reg[1]; mul_b = sm_reg[1]; end
            5'd8:  begin mul_a = sm_reg[2]; mul_b = sm_reg[2]; end
            5'd9:  begin mul_a = {8'd0, radius_reg}; mul_b = {8'd0, radius_reg}; end
            5'd12: begin mul_a = diff_reg[31:0];  mul_b = ns_reg[31:0];    end
            5'd13: begin mul_a = diff_reg[31:0];  mul_b = ns_reg[63:32];   end
            5'd14: begin mul_a = diff_reg[63:32]; mul_b = ns_reg[31:0];    end
            5'd15: begin mul_a = diff_reg[63:32]; mul_b = ns_reg[63:32];   end
            5'd16: begin mul_a = dmag_reg[31:0];  mul_b = dmag_reg[31:0];  end
            5'd17: begin mul_a = dmag_reg[31:0];  mul_b = dmag_reg[63:32]; end
            5'd18: begin mul_a = dmag_reg[63:32]; mul_b = dmag_reg[31:0];  end
            5'd19: begin mul_a = dmag_reg[63:32]; mul_b = dmag_reg[63:32]; end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // flag and shadow-time update for the finishing beat
    always_comb
    begin
        flag_next = flag_reg;
        last_next = last_reg;
        seen_next = seen_reg;
        if (night_reg && !shadow_reg)
            flag_next = 1'b0;
        if (shadow_reg)
        begin
            flag_next = 1'b1;
            last_next = epoch_reg;
            seen_next = 1'b1;
        end
        else if (seen_reg &&
                 ((epoch_reg < last_reg) || (32'(epoch_reg - last_reg) <= {16'd0, hold_reg})))
        begin
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            radius_reg       <= EARTH_RADIUS_RESET;
            hold_reg         <= HOLD_SECONDS_RESET;
            flag_reg         <= 1'b0;
            last_reg         <= '0;
            seen_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                step_reg <= '0;
            else if (state_reg == ST_RUN)
                step_reg <= step_reg + 1'b1;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_EARTH_RADIUS)
                    radius_reg <= cfg_data[23:0];
                else if (cfg_index == REG_HOLD_SECONDS)
                    hold_reg <= cfg_data[15:0];
            end

            if (done_fire)
            begin
                flag_reg         <= flag_next;
                last_reg         <= last_next;
                seen_reg         <= seen_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (accept)
        begin
            pm_reg[0]  <= item.sat_x[31] ? 32'(~item.sat_x + 32'sd1) : 32'(item.sat_x);
            pm_reg[1]  <= item.sat_y[31] ? 32'(~item.sat_y + 32'sd1) : 32'(item.sat_y);
            pm_reg[2]  <= item.sat_z[31] ? 32'(~item.sat_z + 32'sd1) : 32'(item.sat_z);
            sm_reg[0]  <= item.sun_x[31] ? 32'(~item.sun_x + 32'sd1) : 32'(item.sun_x);
            sm_reg[1]  <= item.sun_y[31] ? 32'(~item.sun_y + 32'sd1) : 32'(item.sun_y);
            sm_reg[2]  <= item.sun_z[31] ? 32'(~item.sun_z + 32'sd1) : 32'(item.sun_z);
            neg_reg    <= {item.sat_z[31] ^ item.sun_z[31],
                           item.sat_y[31] ^ item.sun_y[31],
                           item.sat_x[31] ^ item.sun_x[31]};
            epoch_reg  <= item.epoch_seconds;
            dot_reg    <= '0;
            pn_reg     <= '0;
            ns_reg     <= '0;
            lhs_reg    <= '0;
            rhs_reg    <= '0;
        end
        else if (state_reg == ST_RUN)
        begin
            // accumulate the product issued on the previous step
            case (step_reg)
                5'd1:  dot_reg <= neg_reg[0] ? dot_reg - $signed({1'b0, prod_reg})
                                             : dot_reg + $signed({1'b0, prod_reg});
                5'd2:  dot_reg <= neg_reg[1] ? dot_reg - $signed({1'b0, prod_reg})
                                             : dot_reg + $signed({1'b0, prod_reg});
                5'd3:  dot_reg <= neg_reg[2] ? dot_reg - $signed({1'b0, prod_reg})
                                             : dot_reg + $signed({1'b0, prod_reg});
                5'd4, 5'd5, 5'd6: pn_reg <= pn_reg + prod_reg;
                5'd7, 5'd8, 5'd9: ns_reg <= ns_reg + prod_reg;
                5'd10: r2_reg <= prod_reg[47:0];
                STEP_PREP:
                begin
                    diff_reg  <= pn_reg - {16'd0, r2_reg};
                    le_reg    <= pn_reg <= {16'd0, r2_reg};
                    night_reg <= dot_reg[64];
                    dmag_reg  <= 64'(-dot_reg);
                end
                5'd13:        lhs_reg <= lhs_reg + {64'd0, prod_reg};
                5'd14, 5'd15: lhs_reg <= lhs_reg + {32'd0, prod_reg, 32'd0};
                5'd16:        lhs_reg <= lhs_reg + {prod_reg, 64'd0};
                5'd17:        rhs_reg <= rhs_reg + {64'd0, prod_reg};
                5'd18, 5'd19: rhs_reg <= rhs_reg + {32'd0, prod_reg, 32'd0};
                5'd20:        rhs_reg <= rhs_reg + {prod_reg, 64'd0};
                STEP_COMPARE: shadow_reg <= night_reg && (le_reg || (lhs_reg < rhs_reg));
                default: ;
            endcase
        end

        if (done_fire)
        begin
            result_reg.in_eclipse    <= flag_next;
            result_reg.in_shadow_now <= shadow_reg;
        end
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished beat");

    a_shadow_implies_eclipse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!result_reg.in_shadow_now || result_reg.in_eclipse))
        else $error("shadow result without eclipse flag");

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN) && (step_reg == '0))
        else $error("sequencer did not start on accepted beat");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(seen_reg))
        else $error("shadow record cleared outside reset");

endmodule

[test/satellite_eclipse_detector_core_tb.sv]
// Self-checking testbench for the eclipse detector: directed table, random epochs, predictor.
module satellite_eclipse_detector_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import seclip_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd2;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SUN_KM = 32'sd150000000;
    localparam int ITEMS_PER_PHASE = 460;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD = 400;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct {
        item_t   stim;
        logic    typed;
        result_t want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    item_t                  item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // typed expectation travels with each beat of the directed table
    logic    item_typed = 1'b0;
    result_t item_want = '0;

    logic [23:0] radius_m = EARTH_RADIUS_RESET;
    logic [15:0] hold_s = HOLD_SECONDS_RESET;
    logic        ecl_flag = 1'b0;
    logic [31:0] last_shadow_s = '0;
    logic        shadow_recorded = 1'b0;

    result_t  eclipse_expected_q[$];
    result_t  predicted;
    result_t  oldest;
    dir_row_t dir_rows[$];

    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 0;
    int          rcv_idle_pct = 0;
    logic        hold_armed = 1'b0;
    logic        hold_taken = 1'b0;
    logic [31:0] epoch_now = 32'd10000;

    satellite_eclipse_detector_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic result_t predict_eclipse(input item_t it);
        logic signed [65:0] px, py, pz, ux, uy, uz;
        logic signed [65:0] dot, pn_s, un_s;
        logic [65:0]        pn, un, r2;
        logic [127:0]       lhs, rhs;
        logic [31:0]        ep;
        logic               shadow;
        result_t            r;
        px = it.sat_x;
        py = it.sat_y;
        pz = it.sat_z;
        ux = it.sun_x;
        uy = it.sun_y;
        uz = it.sun_z;
        ep = it.epoch_seconds;
        shadow = 1'b0;
        dot = px * ux + py * uy + pz * uz;
        if (dot < 0)
        begin
            pn_s = px * px + py * py + pz * pz;
            un_s = ux * ux + uy * uy + uz * uz;
            pn = $unsigned(pn_s);
            un = $unsigned(un_s);
            r2 = 66'(radius_m) * 66'(radius_m);
            if (pn <= r2)
                shadow = 1'b1;
            else
            begin
                lhs = 128'(pn - r2) * 128'(un);
                rhs = 128'($unsigned(-dot)) * 128'($unsigned(-dot));
                shadow = lhs < rhs;
            end
            if (!shadow)
                ecl_flag = 1'b0;
        end
        if (shadow)
        begin
            ecl_flag = 1'b1;
            last_shadow_s = ep;
            shadow_recorded = 1'b1;
        end
        else if (shadow_recorded)
        begin
            if (ep < last_shadow_s || (ep - last_shadow_s) <= {16'd0, hold_s})
                ecl_flag = 1'b1;
        end
        r.in_eclipse = ecl_flag;
        r.in_shadow_now = shadow;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // beat acceptance, config tracking and result checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_EARTH_RADIUS)
                    radius_m = cfg_data;
                else if (cfg_index == REG_HOLD_SECONDS)
                    hold_s = cfg_data[15:0];
            end
            if (item_valid && !item_stall)
            begin
                predicted = predict_eclipse(item);
                eclipse_expected_q.push_back(item_typed ? item_want : predicted);
            end
            if (result_valid && !result_stall)
            begin
                if (eclipse_expected_q.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    oldest = eclipse_expected_q.pop_front();
                    if (result.in_eclipse !== oldest.in_eclipse)
                        report_mismatch($sformatf("in_eclipse got %b want %b",
                                                  result.in_eclipse, oldest.in_eclipse));
                    if (result.in_shadow_now !== oldest.in_shadow_now)
                        report_mismatch($sformatf("in_shadow_now got %b want %b",
                                                  result.in_shadow_now, oldest.in_shadow_now));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side back-pressure, with one long hold-off to fill the block
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_taken)
            begin
                hold_taken = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
                result_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    task automatic send_epoch(input item_t it, input logic typed, input result_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        item_typed <= typed;
        item_want <= want;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (eclipse_expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void add_row(input logic signed [31:0] sx, input logic signed [31:0] sy,
                                    input logic signed [31:0] sz, input logic signed [31:0] ux,
                                    input logic signed [31:0] uy, input logic signed [31:0] uz,
                                    input logic [31:0] ep, input logic typed,
                                    input logic ecl, input logic shad);
        dir_row_t row;
        row.stim.sat_x = sx;
        row.stim.sat_y = sy;
        row.stim.sat_z = sz;
        row.stim.sun_x = ux;
        row.stim.sun_y = uy;
        row.stim.sun_z = uz;
        row.stim.epoch_seconds = ep;
        row.typed = typed;
        row.want.in_eclipse = ecl;
        row.want.in_shadow_now = shad;
        dir_rows.push_back(row);
    endfunction

    function automatic logic signed [31:0] rand_span(input int bits);
        logic signed [31:0] raw;
        raw = $urandom;
        return raw >>> (32 - bits);
    endfunction

    function automatic item_t next_epoch_item();
        item_t it;
        int    pick;
        int    scale;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            // near the anti-Sun line, straddling the shadow edge
            it.sun_x = rand_span(21);
            it.sun_y = rand_span(21);
            it.sun_z = rand_span(21);
            scale = $urandom_range(2, 40);
            it.sat_x = -(it.sun_x * scale) + rand_span(24);
            it.sat_y = -(it.sun_y * scale) + rand_span(24);
            it.sat_z = -(it.sun_z * scale) + rand_span(24);
        end
        else if (pick < 60)
        begin
            it.sun_x = rand_span(28);
            it.sun_y = rand_span(28);
            it.sun_z = rand_span(28);
            it.sat_x = rand_span(22);
            it.sat_y = rand_span(22);
            it.sat_z = rand_span(22);
        end
        else if (pick < 85)
        begin
            it.sun_x = rand_span(28);
            it.sun_y = rand_span(28);
            it.sun_z = rand_span(28);
            it.sat_x = rand_span(27);
            it.sat_y = rand_span(27);
            it.sat_z = rand_span(27);
        end
        else
        begin
            it.sun_x = $urandom;
            it.sun_y = $urandom;
            it.sun_z = $urandom;
            it.sat_x = $urandom;
            it.sat_y = $urandom;
            it.sat_z = $urandom;
        end
        pick = $urandom_range(99);
        if (pick < 5)
            epoch_now = epoch_now - $urandom_range(0, 3000);
        else if (pick < 10)
            epoch_now = $urandom;
        else
            epoch_now = epoch_now + $urandom_range(0, 900);
        it.epoch_seconds = epoch_now;
        return it;
    endfunction

    task automatic run_random(input int count);
        repeat (count)
            send_epoch(next_epoch_item(), 1'b0, '0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        src_idle_pct = 29;
        rcv_idle_pct = 49;

        add_row(7000000, 0, 0, SUN_KM, 0, 0, 100, 1'b1, 1'b0, 1'b0);
        add_row(-7000000, 0, 0, 0, 0, 0, 110, 1'b1, 1'b0, 1'b0);
        add_row(0, 0, 0, SUN_KM, 0, 0, 120, 1'b1, 1'b0, 1'b0);
        add_row(-7000000, 0, 0, SUN_KM, 0, 0, 1000, 1'b1, 1'b1, 1'b1);
        add_row(-7000000, 7000000, 0, SUN_KM, 0, 0, 1500, 1'b1, 1'b1, 1'b0);
        add_row(-7000000, 7000000, 0, SUN_KM, 0, 0, 2800, 1'b1, 1'b1, 1'b0);
        add_row(-7000000, 7000000, 0, SUN_KM, 0, 0, 2801, 1'b1, 1'b0, 1'b0);
        add_row(7000000, 0, 0, SUN_KM, 0, 0, 2900, 1'b1, 1'b0, 1'b0);
        add_row(-7000000, 7000000, 0, SUN_KM, 0, 0, 500, 1'b1, 1'b1, 1'b0);
        add_row(7000000, 0, 0, SUN_KM, 0, 0, 3000, 1'b1, 1'b1, 1'b0);
        add_row(-1000, 5000000, 0, 1, 0, 0, 4000, 1'b1, 1'b1, 1'b1);
        add_row(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, 32'hFFFF_FFFF,
                1'b0, 1'b0, 1'b0);
        add_row(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN, 0, 1'b0, 1'b0, 1'b0);
        add_row(S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 5, 1'b0, 1'b0, 1'b0);
        add_row(S32_MAX, S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MAX, 32'h8000_0000,
                1'b0, 1'b0, 1'b0);
        add_row(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, 32'h7FFF_FFFF,
                1'b0, 1'b0, 1'b0);
        add_row(0, 0, S32_MIN, 0, 0, S32_MAX, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        add_row(S32_MAX, 0, 0, 0, S32_MAX, 0, 32'h5555_5555, 1'b0, 1'b0, 1'b0);
        add_row(-1, -1, -1, 1, 1, 1, 32'h5555_5556, 1'b0, 1'b0, 1'b0);
        add_row(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'hAAAA_AAAA,
                1'b0, 1'b0, 1'b0);

        foreach (dir_rows[i])
            send_epoch(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
        settle();

        // zero radius, zero hold; upper data bits must not leak into hold
        write_reg(REG_EARTH_RADIUS, 24'd0);
        write_reg(REG_HOLD_SECONDS, 24'hFF0000);
        run_random(ITEMS_PER_PHASE);
        settle();

        src_idle_pct = 49;
        rcv_idle_pct = 29;
        write_reg(REG_EARTH_RADIUS, 24'hFFFFFF);
        write_reg(REG_HOLD_SECONDS, 24'hFFFFFF);
        hold_armed = 1'b1;
        run_random(ITEMS_PER_PHASE);
        settle();

        src_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(REG_UNMAPPED, 24'd12345);
        write_reg(REG_EARTH_RADIUS, 24'($urandom));
        write_reg(REG_HOLD_SECONDS, 24'($urandom));
        run_random(ITEMS_PER_PHASE);
        settle();

        write_reg(REG_EARTH_RADIUS, EARTH_RADIUS_RESET);
        write_reg(REG_HOLD_SECONDS, {8'h00, HOLD_SECONDS_RESET});
        run_random(ITEMS_PER_PHASE);
        settle();

        if (mismatch_count == 0 && eclipse_expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
sv/seclip_pkg.sv
sv/satellite_eclipse_detector_core.sv
test/satellite_eclipse_detector_core_tb.sv
